>>> design/jspwm_pkg.sv
// ----------------------------------------------------------------------------
// jspwm_pkg
// shared types and constants for the joystick jogged servo pwm controller
// ----------------------------------------------------------------------------
package jspwm_pkg;

    localparam int unsigned ANGLE_W    = 8;
    localparam int unsigned SAMPLE_W   = 10;
    localparam int unsigned PULSE_W    = 16;
    localparam int unsigned PINS_W     = 4;
    localparam int unsigned CH_SEL_W   = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [ANGLE_W-1:0]  MAX_ANGLE      = 8'd180;
    localparam logic [ANGLE_W-1:0]  RST_ANGLE      = 8'd90;
    localparam logic [CH_SEL_W-1:0] CLOSE_CHANNEL  = 2'd3;
    localparam logic [PULSE_W-1:0]  PULSE_MAX      = 16'hFFFF;

    // floor(a * 208 / 100) == (a * 2181088) >> 20 for every 8-bit a
    localparam int unsigned         PULSE_MULT_W   = 22;
    localparam int unsigned         PULSE_SHIFT    = 20;
    localparam int unsigned         PULSE_PROD_W   = ANGLE_W + PULSE_MULT_W;
    localparam logic [PULSE_MULT_W-1:0] PULSE_MULT = 22'd2181088;

    localparam logic [CH_SEL_W-1:0] RST_CH_SEL     = 2'd0;
    localparam logic [SAMPLE_W-1:0] RST_LOW_THR    = 10'd450;
    localparam logic [SAMPLE_W-1:0] RST_HIGH_THR   = 10'd750;
    localparam logic [ANGLE_W-1:0]  RST_STEP       = 8'd5;
    localparam logic [PULSE_W-1:0]  RST_PERIOD     = 16'd5000;
    localparam logic [PULSE_W-1:0]  RST_BASE       = 16'd375;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CH_SEL   = 3'd0,
        CFG_LOW_THR  = 3'd1,
        CFG_HIGH_THR = 3'd2,
        CFG_STEP     = 3'd3,
        CFG_PERIOD   = 3'd4,
        CFG_BASE     = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        CMD_TICK   = 1'b0,
        CMD_SAMPLE = 1'b1
    } cmd_t;

    typedef struct packed {
        logic                cmd;
        logic [SAMPLE_W-1:0] sample;
    } in_word_t;

    typedef struct packed {
        logic [PINS_W-1:0]  pins;
        logic [PULSE_W-1:0] pulse_width;
        logic [ANGLE_W-1:0] angle;
    } out_word_t;

endpackage

>>> design/joystick_servo_pwm_controller_top.sv
// ----------------------------------------------------------------------------
// joystick_servo_pwm_controller_top
// four channel servo pulse generator with joystick angle jog
// ----------------------------------------------------------------------------
// an accepted input word's result word is registered and valid in the next cycle
// throughput: one word per cycle while m_ready is high, set by the single result register stage
// reset (aresetn low, synchronous): angles 90 (close channel 180), counter 0,
// compare value 375, pins low, registers to defaults, no result pending
// ----------------------------------------------------------------------------
module joystick_servo_pwm_controller_top #(
    parameter int unsigned NUM_CHANNELS = 4,
    parameter int unsigned COUNT_WIDTH  = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [jspwm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [jspwm_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  jspwm_pkg::in_word_t                    s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output jspwm_pkg::out_word_t                   m_data
);
    import jspwm_pkg::*;

    localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int unsigned CMP_W = (COUNT_WIDTH > PULSE_W) ? COUNT_WIDTH : PULSE_W;

    // configuration
    logic [CH_SEL_W-1:0] ch_sel_reg;
    logic [SAMPLE_W-1:0] low_thr_reg;
    logic [SAMPLE_W-1:0] high_thr_reg;
    logic [ANGLE_W-1:0]  step_reg;
    logic [PULSE_W-1:0]  period_reg;
    logic [PULSE_W-1:0]  base_reg;

    // state
    logic [ANGLE_W-1:0]     angles_reg [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [PULSE_W-1:0]     cmp_reg;
    logic [PULSE_W-1:0]     cmp_next;
    logic [PINS_W-1:0]      pins_reg;
    logic [PINS_W-1:0]      pins_next;
    logic [ANGLE_W-1:0]     angle_next;
    logic                   ang_we;

    logic                   m_valid_reg;
    out_word_t              m_data_reg;
    out_word_t              m_data_next;

    logic                   accept;
    logic                   ch_ok;
    logic [IDX_W+1:0]       ch_wide;
    logic [IDX_W-1:0]       ch_idx;
    logic [PINS_W-1:0]      ch_bit;
    logic [ANGLE_W-1:0]     ang_cur;
    logic [ANGLE_W:0]       ang_up;
    logic [PULSE_PROD_W-1:0] pulse_prod;
    logic [PULSE_W:0]       pulse_sum;
    logic [COUNT_WIDTH-1:0] count_inc;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign ch_ok   = 32'(ch_sel_reg) < NUM_CHANNELS;
    assign ch_wide = (IDX_W+2)'(ch_sel_reg);
    assign ch_idx  = ch_wide[IDX_W-1:0];
    assign ch_bit  = ch_ok ? (PINS_W'(1) << ch_sel_reg) : '0;
    assign ang_cur = angles_reg[ch_idx];

    // jog and pulse width
    always_comb begin
        ang_up     = (ANGLE_W+1)'(ang_cur) + (ANGLE_W+1)'(step_reg);
        angle_next = ang_cur;
        if (ch_sel_reg == CLOSE_CHANNEL) begin
            angle_next = '0;
        end else if (s_data.sample <= low_thr_reg) begin
            angle_next = (ang_cur >= step_reg) ? ang_cur - step_reg : '0;
        end else if (s_data.sample >= high_thr_reg) begin
            if (ang_cur < MAX_ANGLE) begin
                angle_next = (ang_up > (ANGLE_W+1)'(MAX_ANGLE)) ? MAX_ANGLE
                                                              : ang_up[ANGLE_W-1:0];
            end
        end
        pulse_prod = PULSE_PROD_W'(angle_next) * PULSE_PROD_W'(PULSE_MULT);
        pulse_sum  = (PULSE_W+1)'(base_reg)
                   + (PULSE_W+1)'(pulse_prod[PULSE_PROD_W-1:PULSE_SHIFT]);
    end

    // item update
    always_comb begin
        count_inc  = count_reg + COUNT_WIDTH'(1);
        count_next = count_reg;
        cmp_next   = cmp_reg;
        pins_next  = pins_reg;
        ang_we     = 1'b0;
        if (s_data.cmd == CMD_SAMPLE) begin
            if (ch_ok) begin
                ang_we   = 1'b1;
                cmp_next = pulse_sum[PULSE_W] ? PULSE_MAX : pulse_sum[PULSE_W-1:0];
            end
        end else begin
            count_next = count_inc;
            if (CMP_W'(count_inc) == CMP_W'(cmp_reg)) begin
                pins_next = pins_next & ~ch_bit;
            end
            if (CMP_W'(count_inc) == CMP_W'(period_reg)) begin
                pins_next  = pins_next | ch_bit;
                count_next = '0;
            end
        end
        m_data_next.pins        = pins_next;
        m_data_next.pulse_width = cmp_next;
        m_data_next.angle       = !ch_ok ? '0 : (ang_we ? angle_next : ang_cur);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ch_sel_reg   <= RST_CH_SEL;
            low_thr_reg  <= RST_LOW_THR;
            high_thr_reg <= RST_HIGH_THR;
            step_reg     <= RST_STEP;
            period_reg   <= RST_PERIOD;
            base_reg     <= RST_BASE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_CH_SEL:   ch_sel_reg   <= cfg_wr_data[CH_SEL_W-1:0];
                CFG_LOW_THR:  low_thr_reg  <= cfg_wr_data[SAMPLE_W-1:0];
                CFG_HIGH_THR: high_thr_reg <= cfg_wr_data[SAMPLE_W-1:0];
                CFG_STEP:     step_reg     <= cfg_wr_data[ANGLE_W-1:0];
                CFG_PERIOD:   period_reg   <= cfg_wr_data[PULSE_W-1:0];
                CFG_BASE:     base_reg     <= cfg_wr_data[PULSE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                angles_reg[i] <= (i == int'(CLOSE_CHANNEL)) ? MAX_ANGLE : RST_ANGLE;
            end
            count_reg   <= '0;
            cmp_reg     <= RST_BASE;
            pins_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                if (ang_we) begin
                    angles_reg[ch_idx] <= angle_next;
                end
                count_reg <= count_next;
                cmp_reg   <= cmp_next;
                pins_reg  <= pins_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted word produced no result");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result stage");

    a_angle_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.angle <= MAX_ANGLE))
        else $error("result angle out of range");

    a_close_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_data.cmd == CMD_SAMPLE) && ch_ok
            && (ch_sel_reg == CLOSE_CHANNEL)) |=> (m_data.angle == '0))
        else $error("close channel sample did not zero the angle");

endmodule

>>> verif/joystick_servo_pwm_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_servo_pwm_controller testbench
// drives joystick samples and timer ticks through the valid/ready input
// channel, rewrites the six control registers between idle phases and checks
// every result word against a cycle-free model of angle jog, compare value and
// pin timing, under random source and sink stalls
// ----------------------------------------------------------------------------
module testbench;

    import jspwm_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    cfg_reg_t              cfg_index = CFG_CH_SEL;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_word_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_word_t             m_data;

    // model state
    logic [ANGLE_W-1:0]  jog_angle [4];
    logic [15:0]         period_count;
    logic [PULSE_W-1:0]  pulse_cmp;
    logic [PINS_W-1:0]   pin_state;
    logic [CH_SEL_W-1:0] sel_ch;
    logic [SAMPLE_W-1:0] thr_low;
    logic [SAMPLE_W-1:0] thr_high;
    logic [ANGLE_W-1:0]  step_deg;
    logic [PULSE_W-1:0]  period_len;
    logic [PULSE_W-1:0]  base_width;

    in_word_t    servo_cmds [$];
    out_word_t   servo_results_due [$];
    out_word_t   want_word;

    int unsigned send_idle_pct = 38;
    int unsigned recv_idle_pct = 66;
    logic        hold_send = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned n_errors = 0;
    int unsigned n_samples = 0;
    int unsigned n_ticks = 0;
    int unsigned n_results = 0;
    int unsigned n_writes = 0;
    int unsigned pin_changes = 0;

    joystick_servo_pwm_controller_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void reset_model();
        for (int i = 0; i < 4; i++) begin
            jog_angle[i] = (i == CLOSE_CHANNEL) ? MAX_ANGLE : RST_ANGLE;
        end
        period_count = '0;
        pulse_cmp    = RST_BASE;
        pin_state    = '0;
        sel_ch       = RST_CH_SEL;
        thr_low      = RST_LOW_THR;
        thr_high     = RST_HIGH_THR;
        step_deg     = RST_STEP;
        period_len   = RST_PERIOD;
        base_width   = RST_BASE;
    endfunction

    function automatic out_word_t servo_step(in_word_t w);
        out_word_t         res;
        logic [PINS_W-1:0] ch_bit;
        logic [PINS_W-1:0] old_pins;
        int unsigned       a;
        int unsigned       width;
        ch_bit   = PINS_W'(1) << sel_ch;
        old_pins = pin_state;
        if (w.cmd == CMD_SAMPLE) begin
            a = 32'(jog_angle[sel_ch]);
            if (sel_ch == CLOSE_CHANNEL) begin
                a = 0;
            end else if (w.sample <= thr_low) begin
                if (a > 0)
                    a = (a >= step_deg) ? a - step_deg : 0;
            end else if (w.sample >= thr_high) begin
                if (a < MAX_ANGLE) begin
                    a = a + step_deg;
                    if (a > MAX_ANGLE)
                        a = MAX_ANGLE;
                end
            end
            jog_angle[sel_ch] = ANGLE_W'(a);
            width = base_width + a * 208 / 100;
            pulse_cmp = (width > PULSE_MAX) ? PULSE_MAX : PULSE_W'(width);
        end else begin
            period_count = period_count + 16'd1;
            if (period_count == pulse_cmp)
                pin_state &= ~ch_bit;
            if (period_count == period_len) begin
                pin_state |= ch_bit;
                period_count = '0;
            end
        end
        if (pin_state != old_pins)
            pin_changes++;
        res.pins        = pin_state;
        res.pulse_width = pulse_cmp;
        res.angle       = jog_angle[sel_ch];
        return res;
    endfunction

    // source side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (servo_cmds.size() != 0 && !hold_send && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= servo_cmds.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // sink side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_field(string field, int unsigned want, int unsigned got);
        n_errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                servo_results_due.push_back(servo_step(s_data));
                if (s_data.cmd == CMD_SAMPLE)
                    n_samples++;
                else
                    n_ticks++;
            end
            if (m_valid && m_ready) begin
                n_results++;
                if (servo_results_due.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, m_data);
                end else begin
                    want_word = servo_results_due.pop_front();
                    if (m_data.pins !== want_word.pins)
                        report_field("pins", want_word.pins, m_data.pins);
                    if (m_data.pulse_width !== want_word.pulse_width)
                        report_field("pulse_width", want_word.pulse_width, m_data.pulse_width);
                    if (m_data.angle !== want_word.angle)
                        report_field("angle", want_word.angle, m_data.angle);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     servo_results_due.size());
            $display("** joystick_servo_pwm_controller_top: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        n_writes++;
        case (idx)
            CFG_CH_SEL:   sel_ch     = val[CH_SEL_W-1:0];
            CFG_LOW_THR:  thr_low    = val[SAMPLE_W-1:0];
            CFG_HIGH_THR: thr_high   = val[SAMPLE_W-1:0];
            CFG_STEP:     step_deg   = val[ANGLE_W-1:0];
            CFG_PERIOD:   period_len = val[PULSE_W-1:0];
            CFG_BASE:     base_width = val[PULSE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        while (servo_cmds.size() != 0 || s_valid || servo_results_due.size() != 0)
            @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic push_sample(logic [SAMPLE_W-1:0] value);
        in_word_t w;
        w.cmd    = CMD_SAMPLE;
        w.sample = value;
        servo_cmds.push_back(w);
    endtask

    task automatic push_ticks(int unsigned n);
        in_word_t w;
        repeat (n) begin
            w.cmd    = CMD_TICK;
            w.sample = SAMPLE_W'($urandom_range(0, 1023));
            servo_cmds.push_back(w);
        end
    endtask

    task automatic random_setup();
        logic [CFG_DATA_W-1:0] word;
        logic [SAMPLE_W-1:0]   lo;
        logic [SAMPLE_W-1:0]   hi;
        logic [SAMPLE_W-1:0]   tmp;
        int unsigned           per;
        lo = SAMPLE_W'($urandom_range(0, 1023));
        hi = SAMPLE_W'($urandom_range(0, 1023));
        case ($urandom_range(0, 9))
            0: begin
                lo = '0;
                hi = '1;
            end
            1: begin
                lo = '1;
                hi = '0;
            end
            2: ;
            default: begin
                if (lo > hi) begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
            end
        endcase
        // upper bits of each write are junk and must be ignored
        word = CFG_DATA_W'($urandom());
        word[CH_SEL_W-1:0] = CH_SEL_W'($urandom_range(0, 3));
        write_reg(CFG_CH_SEL, word);
        word = CFG_DATA_W'($urandom());
        word[SAMPLE_W-1:0] = lo;
        write_reg(CFG_LOW_THR, word);
        word = CFG_DATA_W'($urandom());
        word[SAMPLE_W-1:0] = hi;
        write_reg(CFG_HIGH_THR, word);
        word = CFG_DATA_W'($urandom());
        case ($urandom_range(0, 5))
            0: word[ANGLE_W-1:0] = '0;
            1: word[ANGLE_W-1:0] = MAX_ANGLE;
            2: word[ANGLE_W-1:0] = 8'd1;
            default: word[ANGLE_W-1:0] = ANGLE_W'($urandom_range(2, 40));
        endcase
        write_reg(CFG_STEP, word);
        // keep the period above the running count so the pin keeps toggling
        per = period_count + $urandom_range(10, 300);
        if ($urandom_range(0, 9) == 0 || per > 65535)
            per = 65535;
        write_reg(CFG_PERIOD, CFG_DATA_W'(per));
        case ($urandom_range(0, 9))
            0: word = '0;
            1: word = PULSE_MAX;
            2: word = CFG_DATA_W'($urandom_range(60000, 65535));
            default: word = CFG_DATA_W'($urandom_range(0, 200));
        endcase
        write_reg(CFG_BASE, word);
        end_writes();
    endtask

    task automatic push_random_block(int unsigned n);
        in_word_t    w;
        int unsigned r;
        repeat (n) begin
            r        = $urandom_range(0, 99);
            w.sample = SAMPLE_W'($urandom_range(0, 1023));
            if (r < 55) begin
                w.cmd = CMD_TICK;
            end else begin
                w.cmd = CMD_SAMPLE;
                if (r < 72)
                    w.sample = SAMPLE_W'($urandom_range(0, thr_low));
                else if (r < 89)
                    w.sample = SAMPLE_W'($urandom_range(thr_high, 1023));
            end
            servo_cmds.push_back(w);
        end
    endtask

    initial begin
        int unsigned target;
        reset_model();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // jog around the thresholds from the reset angle
        push_sample(10'd1023);
        push_sample(10'd750);
        push_sample(10'd749);
        push_sample(10'd451);
        push_sample(10'd450);
        push_sample(10'd0);
        push_ticks(2);
        wait_idle();

        // saturation at both ends
        write_reg(CFG_STEP, CFG_DATA_W'(MAX_ANGLE));
        end_writes();
        push_sample(10'd1023);
        push_sample(10'd1023);
        push_sample(10'd0);
        push_sample(10'd0);
        wait_idle();
        write_reg(CFG_STEP, '0);
        end_writes();
        push_sample(10'd1023);
        wait_idle();

        // close channel
        write_reg(CFG_CH_SEL, CFG_DATA_W'(CLOSE_CHANNEL));
        end_writes();
        push_sample(10'd512);
        push_ticks(1);
        wait_idle();

        // overlapping thresholds, step down wins
        write_reg(CFG_CH_SEL, 16'd1);
        write_reg(CFG_LOW_THR, 16'd800);
        write_reg(CFG_HIGH_THR, 16'd200);
        write_reg(CFG_STEP, 16'd7);
        end_writes();
        push_sample(10'd500);
        push_sample(10'd1023);
        push_sample(10'd100);
        wait_idle();

        // pulse width clamps
        write_reg(CFG_BASE, PULSE_MAX);
        end_writes();
        push_sample(10'd900);
        wait_idle();

        // compare and period hit on the same tick
        target = period_count + 3;
        write_reg(CFG_CH_SEL, 16'd2);
        write_reg(CFG_LOW_THR, 16'd1023);
        write_reg(CFG_HIGH_THR, 16'd1023);
        write_reg(CFG_STEP, CFG_DATA_W'(MAX_ANGLE));
        write_reg(CFG_BASE, CFG_DATA_W'(target));
        write_reg(CFG_PERIOD, CFG_DATA_W'(target));
        end_writes();
        push_sample(10'd1023);
        push_ticks(3);
        wait_idle();
        write_reg(CFG_PERIOD, 16'd1);
        end_writes();
        push_ticks(2);
        wait_idle();

        for (int blk = 0; blk < 17; blk++) begin
            if (blk < 6) begin
                send_idle_pct = 38;
                recv_idle_pct = 66;
            end else if (blk < 12) begin
                send_idle_pct = 66;
                recv_idle_pct = 38;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_setup();
            push_random_block(100);
            if (blk == 3) begin
                while (servo_cmds.size() > 50)
                    @(negedge aclk);
                hold_send = 1'b1;
                while (s_valid || servo_results_due.size() != 0)
                    @(negedge aclk);
                hold_send = 1'b0;
            end
            wait_idle();
        end

        // zero period: counter runs on past the old period without a restart
        write_reg(CFG_CH_SEL, '0);
        write_reg(CFG_LOW_THR, 16'd1023);
        write_reg(CFG_STEP, CFG_DATA_W'(MAX_ANGLE));
        write_reg(CFG_BASE, '0);
        write_reg(CFG_PERIOD, '0);
        end_writes();
        push_sample(10'd0);
        push_ticks(40);
        wait_idle();

        $display("covered %0d sample and %0d tick words over %0d register writes",
                 n_samples, n_ticks, n_writes);
        $display("checked %0d result words, %0d pin level changes", n_results, pin_changes);
        if (n_errors == 0) begin
            $display("** joystick_servo_pwm_controller_top: PASSED **");
        end else begin
            $display("** joystick_servo_pwm_controller_top: FAILED **");
        end
        $finish;
    end

endmodule

>>> sim.f
design/jspwm_pkg.sv
design/joystick_servo_pwm_controller_top.sv
verif/joystick_servo_pwm_controller_tb.sv
